// ----- hdl/sssr_pkg.sv -----
// Shared types, register codes and the binomial table for the subset sort, sign and rank block.
// No dependencies; every other file imports this package.
`default_nettype none

package sssr_pkg;

	localparam int LABEL_W    = 4;
	localparam int NUM_LABELS = 8;
	localparam int RANK_W     = 14;
	localparam int K_W        = 4;
	localparam int N_W        = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SUBSET_SIZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SET_SIZE    = 2'd1;

	// Reset values of the configuration registers
	localparam logic [K_W-1:0] SUBSET_SIZE_RST = 4'd3;
	localparam logic [N_W-1:0] SET_SIZE_RST    = 5'd9;

	// Sign codes
	localparam logic signed [1:0] SIGN_ZERO = 2'sb00;
	localparam logic signed [1:0] SIGN_POS  = 2'sb01;
	localparam logic signed [1:0] SIGN_NEG  = 2'sb11;

	// Binomial table covers C(a, b) for a in 0..16 and b in 0..8
	localparam int CHOOSE_A   = 17;
	localparam int CHOOSE_B   = 9;
	localparam int CHOOSE_N   = CHOOSE_A * CHOOSE_B;
	localparam int CHOOSE_IDX = $clog2(CHOOSE_N);

	typedef logic [LABEL_W-1:0] label_t;
	typedef logic [RANK_W-1:0]  rank_t;
	typedef rank_t              choose_tab_t [CHOOSE_N];

	// Control word that travels with each request down the pipeline
	typedef struct packed {
		logic [K_W-1:0] k;
		logic [N_W-1:0] n;
		logic           invalid;
		logic           repeat_hit;
		logic           parity;
	} ctrl_t;

	// Build Pascal's triangle at elaboration
	function automatic choose_tab_t build_choose();
		choose_tab_t t;
		for (int a = 0; a < CHOOSE_A; a++) begin
			for (int b = 0; b < CHOOSE_B; b++) begin
				if (b == 0)
					t[a*CHOOSE_B + b] = rank_t'(1);
				else if (a == 0)
					t[a*CHOOSE_B + b] = rank_t'(0);
				else
					t[a*CHOOSE_B + b] = t[(a-1)*CHOOSE_B + b - 1] + t[(a-1)*CHOOSE_B + b];
			end
		end
		return t;
	endfunction

	localparam choose_tab_t CHOOSE_TAB = build_choose();

	// Look up C(a, b); zero outside the table
	function automatic rank_t choose_f(input logic [N_W-1:0] a, input logic [K_W-1:0] b);
		logic [CHOOSE_IDX-1:0] idx;
		rank_t                 res;
		idx = CHOOSE_IDX'(a) * CHOOSE_IDX'(CHOOSE_B) + CHOOSE_IDX'(b);
		if (a >= N_W'(CHOOSE_A) || b >= K_W'(CHOOSE_B))
			res = '0;
		else
			res = CHOOSE_TAB[idx];
		return res;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/sssr_cmp.sv -----
// Stage 1: clamps the configuration, checks label range and compares every pair of labels.
// Depends on sssr_pkg.
`default_nettype none

module sssr_cmp #(
	parameter int LANES  = 8,
	parameter int N_MAX  = 16
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     up_valid,
	output logic                    up_ready,
	input  wire sssr_pkg::label_t   lab [LANES],
	input  wire [sssr_pkg::K_W-1:0] subset_size,
	input  wire [sssr_pkg::N_W-1:0] set_size,
	input  wire                     down_ready,
	output logic                    valid_s1,
	output sssr_pkg::label_t        lab_s1 [LANES],
	output logic [LANES-1:0]        lt_s1 [LANES],
	output sssr_pkg::ctrl_t         ctrl_s1
);
	import sssr_pkg::*;

	logic [K_W-1:0]   k_c;
	logic [N_W-1:0]   n_c;
	logic [LANES-1:0] use_c;
	logic [LANES-1:0] lt_c [LANES];
	logic             invalid_c;
	logic             repeat_c;
	logic             parity_c;

	// Clamp sizes, flag out-of-range and repeated labels, accumulate inversion parity
	always_comb begin
		if (subset_size == '0)
			k_c = K_W'(1);
		else if (subset_size > K_W'(LANES))
			k_c = K_W'(LANES);
		else
			k_c = subset_size;
		n_c = (set_size > N_W'(N_MAX)) ? N_W'(N_MAX) : set_size;
		invalid_c = 1'b0;
		repeat_c  = 1'b0;
		parity_c  = 1'b0;
		for (int i = 0; i < LANES; i++) begin
			use_c[i] = (K_W'(i) < k_c);
			if (use_c[i] && (N_W'(lab[i]) >= n_c))
				invalid_c = 1'b1;
		end
		for (int i = 0; i < LANES; i++) begin
			for (int j = 0; j < LANES; j++) begin
				lt_c[i][j] = use_c[j] && (lab[j] < lab[i]);
				if (j > i && use_c[i] && use_c[j]) begin
					if (lab[i] == lab[j])
						repeat_c = 1'b1;
					else if (lab[i] > lab[j])
						parity_c = ~parity_c;
				end
			end
		end
	end

	assign up_ready = !valid_s1 || down_ready;

	// Advance the valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	// Load the payload on a new request
	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			lab_s1             <= lab;
			lt_s1              <= lt_c;
			ctrl_s1.k          <= k_c;
			ctrl_s1.n          <= n_c;
			ctrl_s1.invalid    <= invalid_c;
			ctrl_s1.repeat_hit <= repeat_c;
			ctrl_s1.parity     <= parity_c;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/sssr_sort.sv -----
// Stage 2: counting sort; each label goes to the slot given by how many used labels lie below it.
// Depends on sssr_pkg.
`default_nettype none

module sssr_sort #(
	parameter int LANES = 8
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     valid_s1,
	output logic                    up_ready,
	input  wire sssr_pkg::label_t   lab_s1 [LANES],
	input  wire [LANES-1:0]         lt_s1 [LANES],
	input  wire sssr_pkg::ctrl_t    ctrl_s1,
	input  wire                     down_ready,
	output logic                    valid_s2,
	output sssr_pkg::label_t        sorted_s2 [LANES],
	output logic [sssr_pkg::N_W-1:0] start_s2 [LANES],
	output sssr_pkg::ctrl_t         ctrl_s2
);
	import sssr_pkg::*;

	localparam int POS_W = (LANES > 1) ? $clog2(LANES) : 1;

	logic [POS_W-1:0] pos_c [LANES];
	label_t           sorted_c [LANES];
	logic [N_W-1:0]   start_c [LANES];

	// Scatter used labels into sorted slots and derive each slot's first candidate
	always_comb begin
		for (int i = 0; i < LANES; i++)
			pos_c[i] = POS_W'($countones(lt_s1[i]));
		for (int p = 0; p < LANES; p++) begin
			sorted_c[p] = '0;
			for (int i = 0; i < LANES; i++) begin
				if ((K_W'(i) < ctrl_s1.k) && (pos_c[i] == POS_W'(p)))
					sorted_c[p] = sorted_c[p] | lab_s1[i];
			end
		end
		start_c[0] = '0;
		for (int p = 1; p < LANES; p++)
			start_c[p] = N_W'(sorted_c[p-1]) + N_W'(1);
	end

	assign up_ready = !valid_s2 || down_ready;

	// Advance the valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (up_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	// Load the payload on a new request
	always_ff @(posedge clk) begin
		if (up_ready && valid_s1) begin
			sorted_s2 <= sorted_c;
			start_s2  <= start_c;
			ctrl_s2   <= ctrl_s1;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/sssr_rank.sv -----
// Stages 3 and 4: binomial lookups per sorted slot, then the adder tree and the output register.
// Depends on sssr_pkg.
`default_nettype none

module sssr_rank #(
	parameter int LANES = 8
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      valid_s2,
	output logic                     up_ready,
	input  wire sssr_pkg::label_t    sorted_s2 [LANES],
	input  wire [sssr_pkg::N_W-1:0]  start_s2 [LANES],
	input  wire sssr_pkg::ctrl_t     ctrl_s2,
	input  wire                      out_ready,
	output logic                     out_valid,
	output logic signed [1:0]        perm_sign,
	output logic [sssr_pkg::RANK_W-1:0] subset_rank,
	output logic                     label_invalid
);
	import sssr_pkg::*;

	logic           valid_s3;
	rank_t          term_s3 [LANES];
	ctrl_t          ctrl_s3;
	logic           ready_s3;
	logic           ready_s4;
	logic           zero_s2;
	logic           zero_s3;
	rank_t          term_c [LANES];
	rank_t          sum_c;
	logic [K_W-1:0] r_c;

	// Count subsets that precede each slot: C(n-start, k-p) - C(n-label, k-p)
	assign zero_s2 = ctrl_s2.invalid || ctrl_s2.repeat_hit;
	always_comb begin
		r_c = '0;
		for (int p = 0; p < LANES; p++) begin
			r_c = ctrl_s2.k - K_W'(p);
			if ((K_W'(p) < ctrl_s2.k) && !zero_s2)
				term_c[p] = choose_f(ctrl_s2.n - start_s2[p], r_c)
				          - choose_f(ctrl_s2.n - N_W'(sorted_s2[p]), r_c);
			else
				term_c[p] = '0;
		end
	end

	// Sum the slot terms
	always_comb begin
		sum_c = '0;
		for (int p = 0; p < LANES; p++)
			sum_c = sum_c + term_s3[p];
	end

	assign zero_s3  = ctrl_s3.invalid || ctrl_s3.repeat_hit;
	assign ready_s4 = !out_valid || out_ready;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign up_ready = ready_s3;

	// Advance the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (ready_s3)
				valid_s3 <= valid_s2;
			if (ready_s4)
				out_valid <= valid_s3;
		end
	end

	// Load stage 3 and the output register
	always_ff @(posedge clk) begin
		if (ready_s3 && valid_s2) begin
			term_s3 <= term_c;
			ctrl_s3 <= ctrl_s2;
		end
		if (ready_s4 && valid_s3) begin
			subset_rank   <= zero_s3 ? rank_t'(0) : sum_c;
			label_invalid <= ctrl_s3.invalid;
			if (zero_s3)
				perm_sign <= SIGN_ZERO;
			else if (ctrl_s3.parity)
				perm_sign <= SIGN_NEG;
			else
				perm_sign <= SIGN_POS;
		end
	end

`ifndef ASSERT_OFF
	a_invalid_zero_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && label_invalid |-> perm_sign == SIGN_ZERO)
		else $error("invalid label with nonzero sign");
	a_zero_sign_zero_rank: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && perm_sign == SIGN_ZERO |-> subset_rank == '0)
		else $error("nonzero rank with zero sign");
	a_sign_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> perm_sign == SIGN_ZERO || perm_sign == SIGN_POS || perm_sign == SIGN_NEG)
		else $error("illegal sign code");
	a_rank_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> subset_rank < choose_f(ctrl_s3.n, ctrl_s3.k) || subset_rank == '0
		|| !$past(ready_s4))
		else $error("rank beyond subset count");
`endif

endmodule

`default_nettype wire

// ----- hdl/subset_sort_sign_and_rank.sv -----
// Top level of the subset sort, sign and rank block: configuration registers and pipeline.
// Depends on sssr_pkg, sssr_cmp, sssr_sort and sssr_rank.
`default_nettype none

// Takes one request of eight 4-bit labels per cycle and returns, for each accepted request,
// the sign of the permutation that sorts the first subset_size labels (+1 even, -1 odd,
// 0 on a repeat or an out-of-range label), the lexicographic rank of the sorted subset among all
// subset_size-subsets of {0..set_size-1}, and an invalid flag. The four register stages are the
// pairwise comparator array, the counting-sort scatter, the binomial table lookups and the adder
// tree with the output register; the rate is one request per cycle while out_ready is high. Write
// subset_size (index 0) and set_size (index 1) only while the pipeline is empty; the config port
// never stalls.
module subset_sort_sign_and_rank #(
	parameter int MAX_ELEMENTS = 16,
	parameter int MAX_SUBSET   = 8
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_valid,
	output logic                           cfg_ready,
	input  wire [sssr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire [sssr_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire                            in_valid,
	output logic                           in_ready,
	input  wire [sssr_pkg::LABEL_W-1:0]    label_0,
	input  wire [sssr_pkg::LABEL_W-1:0]    label_1,
	input  wire [sssr_pkg::LABEL_W-1:0]    label_2,
	input  wire [sssr_pkg::LABEL_W-1:0]    label_3,
	input  wire [sssr_pkg::LABEL_W-1:0]    label_4,
	input  wire [sssr_pkg::LABEL_W-1:0]    label_5,
	input  wire [sssr_pkg::LABEL_W-1:0]    label_6,
	input  wire [sssr_pkg::LABEL_W-1:0]    label_7,
	output logic                           out_valid,
	input  wire                            out_ready,
	output logic signed [1:0]              perm_sign,
	output logic [sssr_pkg::RANK_W-1:0]    subset_rank,
	output logic                           label_invalid
);
	import sssr_pkg::*;

	localparam int LANES = MAX_SUBSET;

	logic [K_W-1:0]   subset_size_q;
	logic [N_W-1:0]   set_size_q;
	label_t           lab_all [NUM_LABELS];
	label_t           lab_lane [LANES];
	logic             valid_s1;
	label_t           lab_s1 [LANES];
	logic [LANES-1:0] lt_s1 [LANES];
	ctrl_t            ctrl_s1;
	logic             ready_s1;
	logic             valid_s2;
	label_t           sorted_s2 [LANES];
	logic [N_W-1:0]   start_s2 [LANES];
	ctrl_t            ctrl_s2;
	logic             ready_s2;

	// Accept configuration writes at once; drop unknown indexes
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			subset_size_q <= SUBSET_SIZE_RST;
			set_size_q    <= SET_SIZE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SUBSET_SIZE: subset_size_q <= cfg_data[K_W-1:0];
				REG_SET_SIZE:    set_size_q    <= cfg_data[N_W-1:0];
				default: ;
			endcase
		end
	end

	// Gather the label ports into lanes
	assign lab_all[0] = label_0;
	assign lab_all[1] = label_1;
	assign lab_all[2] = label_2;
	assign lab_all[3] = label_3;
	assign lab_all[4] = label_4;
	assign lab_all[5] = label_5;
	assign lab_all[6] = label_6;
	assign lab_all[7] = label_7;
	always_comb begin
		for (int i = 0; i < LANES; i++)
			lab_lane[i] = lab_all[i];
	end

	sssr_cmp #(
		.LANES (LANES),
		.N_MAX (MAX_ELEMENTS)
	) u_cmp (
		.clk         (clk),
		.arst_n      (arst_n),
		.up_valid    (in_valid),
		.up_ready    (in_ready),
		.lab         (lab_lane),
		.subset_size (subset_size_q),
		.set_size    (set_size_q),
		.down_ready  (ready_s1),
		.valid_s1    (valid_s1),
		.lab_s1      (lab_s1),
		.lt_s1       (lt_s1),
		.ctrl_s1     (ctrl_s1)
	);

	sssr_sort #(
		.LANES (LANES)
	) u_sort (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s1   (valid_s1),
		.up_ready   (ready_s1),
		.lab_s1     (lab_s1),
		.lt_s1      (lt_s1),
		.ctrl_s1    (ctrl_s1),
		.down_ready (ready_s2),
		.valid_s2   (valid_s2),
		.sorted_s2  (sorted_s2),
		.start_s2   (start_s2),
		.ctrl_s2    (ctrl_s2)
	);

	sssr_rank #(
		.LANES (LANES)
	) u_rank (
		.clk           (clk),
		.arst_n        (arst_n),
		.valid_s2      (valid_s2),
		.up_ready      (ready_s2),
		.sorted_s2     (sorted_s2),
		.start_s2      (start_s2),
		.ctrl_s2       (ctrl_s2),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.perm_sign     (perm_sign),
		.subset_rank   (subset_rank),
		.label_invalid (label_invalid)
	);

endmodule

`default_nettype wire

// ----- dv/tb_subset_sort_sign_and_rank.sv -----
// Testbench for subset_sort_sign_and_rank: directed and random label requests under several
// register settings, with its own predictor of sign, rank and invalid flag, checked in order.
// Depends on sssr_pkg and the RTL of subset_sort_sign_and_rank.
module tb_subset_sort_sign_and_rank;
	import sssr_pkg::*;

	localparam int CLK_HALF     = 5;
	localparam int RESET_CYCLES = 7;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int REPORT_MAX   = 10;
	localparam int MAX_K        = 8;
	localparam int MAX_N        = 16;

	// Indexes past the register list; writes there must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	typedef logic [NUM_LABELS-1:0][LABEL_W-1:0] label_vec_t;

	typedef struct packed {
		logic [1:0] sgn;
		rank_t      rank;
		logic       invalid;
	} sort_result_t;

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_e;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_valid = 1'b0;
	wire                   cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  in_valid  = 1'b0;
	wire                   in_ready;
	label_t                label_0   = '0;
	label_t                label_1   = '0;
	label_t                label_2   = '0;
	label_t                label_3   = '0;
	label_t                label_4   = '0;
	label_t                label_5   = '0;
	label_t                label_6   = '0;
	label_t                label_7   = '0;
	wire                   out_valid;
	logic                  out_ready = 1'b0;
	wire signed [1:0]      perm_sign;
	wire [RANK_W-1:0]      subset_rank;
	wire                   label_invalid;

	// Predictor copy of the registers
	logic [K_W-1:0] k_reg = SUBSET_SIZE_RST;
	logic [N_W-1:0] n_reg = SET_SIZE_RST;

	label_vec_t   feed_q[$];
	sort_result_t expected_q[$];
	int           queued_cnt   = 0;
	int           accepted_cnt = 0;
	int           mismatch_cnt = 0;
	logic         in_fire_q    = 1'b0;

	// Stimulus-side view of the registers as last written
	int cur_k = SUBSET_SIZE_RST;
	int cur_n = SET_SIZE_RST;

	subset_sort_sign_and_rank u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.label_0      (label_0),
		.label_1      (label_1),
		.label_2      (label_2),
		.label_3      (label_3),
		.label_4      (label_4),
		.label_5      (label_5),
		.label_6      (label_6),
		.label_7      (label_7),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.perm_sign    (perm_sign),
		.subset_rank  (subset_rank),
		.label_invalid(label_invalid)
	);

	// C(a, b), zero when b exceeds a
	function automatic int binomial(input int a, input int b);
		int c;
		c = 1;
		if (b > a)
			return 0;
		for (int i = 0; i < b; i++)
			c = c * (a - i) / (i + 1);
		return c;
	endfunction

	// Sign of the sorting permutation, lexicographic rank and invalid flag for one request
	function automatic sort_result_t rank_subset(input label_vec_t lv, input logic [K_W-1:0] k_cfg,
			input logic [N_W-1:0] n_cfg);
		sort_result_t   r;
		int             k, n, inversions, pos, acc;
		logic           bad, dup;
		logic [MAX_N-1:0] members;
		k = (k_cfg < 1) ? 1 : (k_cfg > MAX_K) ? MAX_K : int'(k_cfg);
		n = (n_cfg > MAX_N) ? MAX_N : int'(n_cfg);
		bad        = 1'b0;
		dup        = 1'b0;
		inversions = 0;
		members    = '0;
		acc        = 0;
		pos        = 0;
		for (int i = 0; i < k; i++)
			if (int'(lv[i]) >= n)
				bad = 1'b1;
		for (int i = 0; i < k; i++)
			for (int j = i + 1; j < k; j++) begin
				if (lv[i] == lv[j])
					dup = 1'b1;
				else if (lv[i] > lv[j])
					inversions++;
			end
		r.sgn     = SIGN_ZERO;
		r.rank    = '0;
		r.invalid = bad;
		if (!bad && !dup) begin
			for (int i = 0; i < k; i++)
				members[lv[i]] = 1'b1;
			// each absent value below the last member skips the subsets that start with it
			for (int v = 0; v < n; v++) begin
				if (members[v])
					pos++;
				else if (pos < k)
					acc += binomial(n - 1 - v, k - 1 - pos);
			end
			r.rank = rank_t'(acc);
			r.sgn  = inversions[0] ? SIGN_NEG : SIGN_POS;
		end
		return r;
	endfunction

	// Mostly distinct in-range subsets; the rest repeats, out-of-range labels and noise
	function automatic label_vec_t random_subset(input int k_raw, input int n_raw);
		label_vec_t lv;
		int         k, n, pick, j, a, b, tmp;
		int         pool[MAX_N];
		k = (k_raw < 1) ? 1 : (k_raw > MAX_K) ? MAX_K : k_raw;
		n = (n_raw > MAX_N) ? MAX_N : n_raw;
		for (int i = 0; i < NUM_LABELS; i++)
			lv[i] = label_t'($urandom_range(0, 15));
		pick = $urandom_range(0, 99);
		if (pick < 70 && k <= n) begin
			for (int i = 0; i < MAX_N; i++)
				pool[i] = i;
			for (int i = 0; i < n; i++) begin
				j       = $urandom_range(i, n - 1);
				tmp     = pool[i];
				pool[i] = pool[j];
				pool[j] = tmp;
			end
			for (int i = 0; i < k; i++)
				lv[i] = label_t'(pool[i]);
			// pin some to the first or the last subset, in either order
			if (pick < 10) begin
				for (int i = 0; i < k; i++) begin
					tmp = (pick < 5) ? i : n - k + i;
					lv[(pick % 2) ? k - 1 - i : i] = label_t'(tmp);
				end
			end
		end else if (pick < 82 && n > 0) begin
			for (int i = 0; i < k; i++)
				lv[i] = label_t'($urandom_range(0, n - 1));
			if (k > 1) begin
				a = $urandom_range(0, k - 1);
				b = $urandom_range(0, k - 1);
				if (a == b)
					b = (a + 1) % k;
				lv[b] = lv[a];
			end
		end else if (pick < 92 && n < MAX_N) begin
			if (n > 0)
				for (int i = 0; i < k; i++)
					lv[i] = label_t'($urandom_range(0, n - 1));
			lv[$urandom_range(0, k - 1)] = label_t'($urandom_range(n, 15));
		end
		return lv;
	endfunction

	// Clock
	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// Cycle limit
	initial begin
		int cycle_cnt;
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("FAILURE");
		$finish;
	end

	// Request driver: bursts of random length separated by random gaps
	int         gap_left   = 0;
	int         burst_left = 0;
	label_vec_t drive_vec;

	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_fire_q) begin
			// hold the pending request
		end else if (gap_left > 0) begin
			gap_left--;
			in_valid <= 1'b0;
		end else if (feed_q.size() > 0) begin
			drive_vec = feed_q.pop_front();
			in_valid  <= 1'b1;
			label_0   <= drive_vec[0];
			label_1   <= drive_vec[1];
			label_2   <= drive_vec[2];
			label_3   <= drive_vec[3];
			label_4   <= drive_vec[4];
			label_5   <= drive_vec[5];
			label_6   <= drive_vec[6];
			label_7   <= drive_vec[7];
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				burst_left = $urandom_range(1, 40);
				gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12)
					: $urandom_range(0, 2);
			end
		end else begin
			in_valid <= 1'b0;
		end
	end

	// Result receiver: stall pattern switches at random between open, coin-flip, sparse and periodic modes
	rx_mode_e rx_mode   = RX_OPEN;
	int       mode_left = 0;
	int       rx_tick   = 0;

	always @(negedge clk) begin
		if (mode_left == 0) begin
			rx_mode   = rx_mode_e'($urandom_range(0, 3));
			mode_left = $urandom_range(16, 128);
		end else begin
			mode_left--;
		end
		rx_tick++;
		case (rx_mode)
			RX_OPEN:   out_ready <= 1'b1;
			RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
			RX_SPARSE: out_ready <= ($urandom_range(0, 4) == 0);
			default:   out_ready <= ((rx_tick % 7) < 4);
		endcase
	end

	// Monitor: track register writes, predict accepted requests, check results in order
	sort_result_t want;

	always @(posedge clk) begin
		in_fire_q <= arst_n && in_valid && in_ready;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SUBSET_SIZE: k_reg = cfg_data[K_W-1:0];
					REG_SET_SIZE:    n_reg = cfg_data[N_W-1:0];
					default:         ;
				endcase
			end
			if (in_valid && in_ready) begin
				expected_q.push_back(rank_subset({label_7, label_6, label_5, label_4,
					label_3, label_2, label_1, label_0}, k_reg, n_reg));
				accepted_cnt++;
			end
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= REPORT_MAX)
						$display("unexpected result: sign %0d rank %0d invalid %0b",
							perm_sign, subset_rank, label_invalid);
				end else begin
					want = expected_q.pop_front();
					if (perm_sign !== want.sgn || subset_rank !== want.rank
							|| label_invalid !== want.invalid) begin
						mismatch_cnt++;
						if (mismatch_cnt <= REPORT_MAX)
							$display("mismatch: expected sign %0d rank %0d invalid %0b, got sign %0d rank %0d invalid %0b",
								$signed(want.sgn), want.rank, want.invalid,
								perm_sign, subset_rank, label_invalid);
					end
				end
			end
		end
	end

	task automatic queue_item(input label_vec_t lv);
		feed_q.push_back(lv);
		queued_cnt++;
	endtask

	task automatic queue_random(input int count);
		for (int i = 0; i < count; i++)
			queue_item(random_subset(cur_k, cur_n));
	endtask

	// Wait until every request is accepted and answered, then let the pipeline settle
	task automatic wait_drained();
		while (accepted_cnt != queued_cnt || expected_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!(cfg_valid && cfg_ready));
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Drain, then set both registers for the next phase
	task automatic set_phase(input logic [CFG_DATA_W-1:0] k_data, input logic [CFG_DATA_W-1:0] n_data);
		wait_drained();
		write_reg(REG_SUBSET_SIZE, k_data);
		write_reg(REG_SET_SIZE, n_data);
		cur_k = int'(k_data[K_W-1:0]);
		cur_n = int'(n_data);
	endtask

	// Stimulus
	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset setting, 3 of 9: order, parity, last subset, repeats, out-of-range labels
		queue_item({4'hF, 4'hF, 4'hF, 4'hF, 4'hF, 4'd2, 4'd1, 4'd0});
		queue_item({4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'd0, 4'd1, 4'd2});
		queue_item({4'hF, 4'hF, 4'hF, 4'hF, 4'hF, 4'd8, 4'd7, 4'd6});
		queue_item({4'h5, 4'hA, 4'h5, 4'hA, 4'h5, 4'd7, 4'd6, 4'd8});
		queue_item({4'hF, 4'hF, 4'hF, 4'hF, 4'hF, 4'd2, 4'd0, 4'd1});
		queue_item({4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'd1, 4'd4, 4'd4});
		queue_item({4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'd1, 4'd0, 4'd9});
		queue_item({4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'd0, 4'hF, 4'hF});
		queue_item({4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'd0, 4'd0, 4'd0});
		queue_item({4'hF, 4'hF, 4'hF, 4'hF, 4'hF, 4'hF, 4'hF, 4'hF});
		queue_random(70);

		// largest subset of the largest set
		set_phase(5'd8, 5'd16);
		queue_item({4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15});
		queue_item({4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1, 4'd0});
		queue_item({4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7});
		queue_item({4'd15, 4'd14, 4'd13, 4'd12, 4'd11, 4'd10, 4'd0, 4'd9});
		queue_random(80);

		set_phase(5'd1, 5'd1);
		queue_random(50);

		// writes to indexes past the list must leave both registers alone
		set_phase(5'd8, 5'd8);
		write_reg(REG_SPARE_2, 5'd31);
		write_reg(REG_SPARE_3, 5'd0);
		queue_random(80);

		set_phase(5'd1, 5'd16);
		queue_random(60);

		set_phase(5'd5, 5'd12);
		queue_random(90);

		// subset size zero and empty ground set
		set_phase(5'd16, 5'd0);
		queue_random(40);

		// both sizes saturate
		set_phase(5'd15, 5'd31);
		queue_random(70);

		set_phase(5'd9, 5'd17);
		queue_random(50);

		// subset larger than the ground set
		set_phase(5'd6, 5'd3);
		queue_random(40);

		set_phase(5'd4, 5'd10);
		queue_random(90);

		set_phase(5'd2, 5'd5);
		queue_random(70);

		wait_drained();
		if (mismatch_cnt == 0 && expected_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/sssr_pkg.sv
hdl/sssr_cmp.sv
hdl/sssr_sort.sv
hdl/sssr_rank.sv
hdl/subset_sort_sign_and_rank.sv
dv/tb_subset_sort_sign_and_rank.sv
